// ===== hw/rtl/tga_pkg.sv =====
package tga_pkg;

    localparam int unsigned HdrLastPos = 17;

    localparam logic [7:0] TYPE_COLOR     = 8'd2;
    localparam logic [7:0] TYPE_GRAY      = 8'd3;
    localparam logic [7:0] TYPE_COLOR_RLE = 8'd10;

    localparam logic [7:0] DEPTH_8  = 8'd8;
    localparam logic [7:0] DEPTH_24 = 8'd24;
    localparam logic [7:0] DEPTH_32 = 8'd32;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0] PKT_RUN_BIT  = 8'h80;
    localparam logic [7:0] PKT_LEN_MASK = 8'h7F;
    localparam logic [7:0] DESC_TOP_BIT = 8'h20;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_IDSKIP = 3'd1,
        PH_PACKET = 3'd2,
        PH_PIXEL  = 3'd3,
        PH_IDLE   = 3'd4
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [31:0] first_index;
        logic [7:0]  run_count;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [7:0]  depth_bits;
        logic        bottom_up;
        logic        last;
    } result_t;

    localparam int unsigned OutDataW = 120;

endpackage

// ===== hw/rtl/tga_parser.sv =====
module tga_parser
    import tga_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        start_req,
    output logic        res_valid,
    output result_t     res
);

    phase_t      phase_reg, phase_next;
    logic [4:0]  hdr_pos_reg, hdr_pos_next;
    logic [7:0]  id_left_reg, id_left_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [7:0]  depth_reg, depth_next;
    logic [7:0]  type_reg, type_next;
    logic        flip_reg, flip_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] pix_pos_reg, pix_pos_next;
    logic [7:0]  pkt_left_reg, pkt_left_next;
    logic        pkt_run_reg, pkt_run_next;
    logic [1:0]  chan_reg, chan_next;
    logic [23:0] partial_reg, partial_next;

    logic        is_rle;
    logic        fmt_ok;
    logic [31:0] product;
    logic [2:0]  nbytes;
    logic [23:0] colour;
    logic        need_more;
    logic [7:0]  count;
    logic [32:0] pos_sum;
    logic [31:0] remaining;
    logic [7:0]  pix_r, pix_g, pix_b, pix_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            hdr_pos_reg  <= '0;
            id_left_reg  <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            depth_reg    <= '0;
            type_reg     <= '0;
            flip_reg     <= 1'b0;
            total_reg    <= '0;
            pix_pos_reg  <= '0;
            pkt_left_reg <= '0;
            pkt_run_reg  <= 1'b0;
            chan_reg     <= '0;
            partial_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            hdr_pos_reg  <= hdr_pos_next;
            id_left_reg  <= id_left_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            depth_reg    <= depth_next;
            type_reg     <= type_next;
            flip_reg     <= flip_next;
            total_reg    <= total_next;
            pix_pos_reg  <= pix_pos_next;
            pkt_left_reg <= pkt_left_next;
            pkt_run_reg  <= pkt_run_next;
            chan_reg     <= chan_next;
            partial_reg  <= partial_next;
        end
    end

    assign product = {16'd0, width_reg} * {16'd0, height_reg};

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_pos_next  = hdr_pos_reg;
        id_left_next  = id_left_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        depth_next    = depth_reg;
        type_next     = type_reg;
        flip_next     = flip_reg;
        total_next    = total_reg;
        pix_pos_next  = pix_pos_reg;
        pkt_left_next = pkt_left_reg;
        pkt_run_next  = pkt_run_reg;
        chan_next     = chan_reg;
        partial_next  = partial_reg;

        res_valid       = 1'b0;
        res.kind        = KIND_PIXEL;
        res.red         = '0;
        res.green       = '0;
        res.blue        = '0;
        res.alpha       = '0;
        res.first_index = '0;
        res.run_count   = '0;
        res.last        = 1'b0;

        fmt_ok    = 1'b0;
        nbytes    = 3'd1;
        colour    = '0;
        need_more = 1'b0;
        count     = '0;
        pos_sum   = '0;
        remaining = '0;
        pix_r     = '0;
        pix_g     = '0;
        pix_b     = '0;
        pix_a     = '0;

        if (start_req)
        begin
            phase_next    = PH_HEADER;
            hdr_pos_next  = '0;
            id_left_next  = '0;
            width_next    = '0;
            height_next   = '0;
            depth_next    = '0;
            type_next     = '0;
            flip_next     = 1'b0;
            total_next    = '0;
            pix_pos_next  = '0;
            pkt_left_next = '0;
            pkt_run_next  = 1'b0;
            chan_next     = '0;
            partial_next  = '0;
        end

        is_rle = (type_next == TYPE_COLOR_RLE);

        case (phase_next)
            PH_HEADER:
            begin
                case (hdr_pos_next)
                    5'd0:  id_left_next = data_byte;
                    5'd2:  type_next = data_byte;
                    5'd12: width_next[7:0] = data_byte;
                    5'd13: width_next[15:8] = data_byte;
                    5'd14: height_next[7:0] = data_byte;
                    5'd15: height_next[15:8] = data_byte;
                    5'd16: depth_next = data_byte;
                    5'd17: flip_next = ((data_byte & DESC_TOP_BIT) == 8'd0);
                    default: ;
                endcase
                if (hdr_pos_next != 5'(HdrLastPos))
                begin
                    hdr_pos_next = hdr_pos_next + 5'd1;
                end
                else
                begin
                    // byte 17 never coincides with a restart, so stored sizes are current
                    fmt_ok = (type_next == TYPE_COLOR || type_next == TYPE_GRAY ||
                              type_next == TYPE_COLOR_RLE) &&
                             (depth_next == DEPTH_8 || depth_next == DEPTH_24 ||
                              depth_next == DEPTH_32) &&
                             !(type_next == TYPE_COLOR_RLE && depth_next == DEPTH_8);
                    total_next   = product;
                    pix_pos_next = '0;
                    res_valid    = 1'b1;
                    if (!fmt_ok)
                    begin
                        phase_next = PH_IDLE;
                        res.kind   = KIND_ERROR;
                    end
                    else
                    begin
                        res.kind = KIND_HEADER;
                        res.last = (product == 32'd0);
                        if (product == 32'd0)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else if (id_left_next != 8'd0)
                        begin
                            phase_next = PH_IDSKIP;
                        end
                        else
                        begin
                            phase_next   = is_rle ? PH_PACKET : PH_PIXEL;
                            chan_next    = '0;
                            partial_next = '0;
                        end
                    end
                end
            end
            PH_IDSKIP:
            begin
                id_left_next = id_left_next - 8'd1;
                if (id_left_next == 8'd0)
                begin
                    phase_next   = is_rle ? PH_PACKET : PH_PIXEL;
                    chan_next    = '0;
                    partial_next = '0;
                end
            end
            PH_PACKET:
            begin
                pkt_run_next  = ((data_byte & PKT_RUN_BIT) != 8'd0);
                pkt_left_next = (data_byte & PKT_LEN_MASK) + 8'd1;
                chan_next     = '0;
                partial_next  = '0;
                phase_next    = PH_PIXEL;
            end
            PH_PIXEL:
            begin
                if (depth_next == DEPTH_32)
                begin
                    nbytes = 3'd4;
                end
                else if (depth_next == DEPTH_24)
                begin
                    nbytes = 3'd3;
                end
                else
                begin
                    nbytes = 3'd1;
                end

                colour = partial_next;
                case (chan_next)
                    2'd0: colour[7:0] = data_byte;
                    2'd1: colour[15:8] = data_byte;
                    2'd2: colour[23:16] = data_byte;
                    default: ;
                endcase

                if (nbytes == 3'd1)
                begin
                    pix_r = data_byte;
                    pix_g = '0;
                    pix_b = '0;
                    pix_a = ALPHA_OPAQUE;
                end
                else
                begin
                    need_more = ({1'b0, chan_next} + 3'd1) < nbytes;
                    pix_b = colour[7:0];
                    pix_g = colour[15:8];
                    pix_r = colour[23:16];
                    pix_a = (nbytes == 3'd4) ? data_byte : ALPHA_OPAQUE;
                end

                if (need_more)
                begin
                    partial_next = colour;
                    chan_next    = chan_next + 2'd1;
                end
                else
                begin
                    chan_next    = '0;
                    partial_next = '0;
                    if (is_rle && pkt_run_next)
                    begin
                        count         = pkt_left_next;
                        pkt_left_next = '0;
                    end
                    else
                    begin
                        count = 8'd1;
                        if (is_rle)
                        begin
                            pkt_left_next = pkt_left_next - 8'd1;
                        end
                    end
                    // a run reaching past the image end is clipped to the pixels left
                    pos_sum   = {1'b0, pix_pos_next} + {25'd0, count};
                    remaining = total_next - pix_pos_next;
                    res.first_index = pix_pos_next;
                    if (pos_sum > {1'b0, total_next})
                    begin
                        count        = remaining[7:0];
                        pix_pos_next = total_next;
                    end
                    else
                    begin
                        pix_pos_next = pos_sum[31:0];
                    end
                    res.last = (pix_pos_next == total_next);
                    if (res.last)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (is_rle && pkt_left_next == 8'd0)
                    begin
                        phase_next = PH_PACKET;
                    end
                    res_valid     = 1'b1;
                    res.kind      = KIND_PIXEL;
                    res.red       = pix_r;
                    res.green     = pix_g;
                    res.blue      = pix_b;
                    res.alpha     = pix_a;
                    res.run_count = count;
                end
            end
            default: ;
        endcase

        res.image_width  = width_next;
        res.image_height = height_next;
        res.depth_bits   = depth_next;
        res.bottom_up    = flip_next;
    end

endmodule

// ===== hw/rtl/tga_image_stream_decoder.sv =====
// Channel   Dir  tdata                                   tuser       tlast
// s_axis    in   data_byte                               start_req   -
// m_axis    out  red..bottom_up (see port comment)       kind        last
//
// While s_axis_tready is high one file byte is taken per cycle; each byte updates
// the parser as it is taken, and any result is in the output register next cycle.
// s_axis_tready stays high while the output register is empty or being drained,
// so bytes keep flowing back to back until a result is held by m_axis_tready.
// rst_n clears the parser to the header phase and empties the output register.
module tga_image_stream_decoder
    import tga_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,  // [7:0] data_byte
    input  logic                s_axis_tuser,  // [0] start_req
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [63:32] first_index,
    // [71:64] run_count, [87:72] image_width, [103:88] image_height,
    // [111:104] depth_bits, [112] bottom_up, [119:113] zero
    output logic [OutDataW-1:0] m_axis_tdata,
    output logic [1:0]          m_axis_tuser,  // [1:0] kind
    output logic                m_axis_tlast
);

    logic    accept;
    logic    res_valid;
    result_t res;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    tga_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .data_byte (s_axis_tdata),
        .start_req (s_axis_tuser),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_valid_next = (out_valid_reg && !m_axis_tready) || (accept && res_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {7'd0, out_reg.bottom_up, out_reg.depth_bits,
                            out_reg.image_height, out_reg.image_width,
                            out_reg.run_count, out_reg.first_index,
                            out_reg.alpha, out_reg.blue, out_reg.green, out_reg.red};

endmodule
